// ===== hdl/bc_pkg.sv =====
// Package: shared types, register indexes, constants and helpers for barometer compensation.
package bc_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned RawW      = 19;
  localparam int unsigned TempW     = 16;
  localparam int unsigned PresW     = 20;

  localparam logic [CfgIndexW-1:0] REG_AC123 = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_AC456 = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_B12   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_MCMD  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_OSS   = 3'd4;

  localparam logic FUNC_TEMP = 1'b0;
  localparam logic FUNC_PRES = 1'b1;

  localparam logic [63:0] K_B6_OFFSET = 64'd4000;
  localparam logic [63:0] K_B4_OFFSET = 64'd32768;
  localparam logic [31:0] K_B7_SCALE  = 32'd50000;
  localparam logic [63:0] K_P_SQ      = 64'd3038;
  localparam logic [63:0] K_P_LIN     = 64'hFFFF_FFFF_FFFF_E343;  // -7357
  localparam logic [63:0] K_P_OFFSET  = 64'd3791;
  localparam logic [63:0] K_P_MAX     = 64'd1048575;
  localparam logic [63:0] K_T_MAX     = 64'd32767;
  localparam logic [63:0] K_T_MIN     = 64'hFFFF_FFFF_FFFF_8000;  // -32768

  typedef enum logic [4:0] {
    S_IDLE, S_TX1, S_TDEN, S_TDIV, S_TFIN,
    S_PSQ, S_PX1A, S_PX2A, S_PB3, S_PX1B, S_PX2B, S_PX3,
    S_PB4, S_PB7, S_PDLD, S_PDIV, S_PQ, S_PF1, S_PF2, S_PF3, S_PFIN,
    S_OUT
  } bc_state_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] zx16(input logic [15:0] v);
    return {48'd0, v};
  endfunction

  // signed shift right that truncates toward zero
  function automatic logic [63:0] sdiv2(input logic [63:0] x, input logic [5:0] k);
    logic [63:0] bias;
    bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    return 64'($signed(x + bias) >>> k);
  endfunction

endpackage

// ===== hdl/bc_in_if.sv =====
// Interface: raw reading channel.
interface bc_in_if import bc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            func;
  logic [RawW-1:0] raw_value;

  modport source (output valid, func, raw_value, input ready);
  modport sink   (input valid, func, raw_value, output ready);
endinterface

// ===== hdl/bc_out_if.sv =====
// Interface: compensated result channel.
interface bc_out_if import bc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [TempW-1:0] temperature_tenths;
  logic [PresW-1:0]        pressure_pa;
  logic                    divide_by_zero;
  logic                    saturated;

  modport source (output valid, kind, temperature_tenths, pressure_pa, divide_by_zero,
                  saturated, input ready);
  modport sink   (input valid, kind, temperature_tenths, pressure_pa, divide_by_zero,
                  saturated, output ready);
endinterface

// ===== hdl/barometer_compensation.sv =====
// Barometer compensation: one shared 64x16 multiplier and a radix-2 divider under a sequencer.
// Each raw reading is taken only while the block is idle. A temperature item runs one
// multiply, one 32-step division and a few single steps before its result. A pressure
// item runs ten multiplies on the shared multiplier (16 bits of operand per cycle), one
// 32-step division and six single steps. The next reading can be taken while a result
// waits on the output.
module barometer_compensation import bc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  bc_in_if.sink                sample,
  bc_out_if.source             result
);

  bc_state_t state, state_next;

  logic [47:0] coef_ac123, coef_ac456;
  logic [31:0] coef_b12, coef_mcmd;
  logic [1:0]  oss;
  logic [31:0] last_b5;

  logic            func;
  logic [RawW-1:0] raw;
  logic [63:0]     x1, x2, x3, sq, b3, b6, p;
  logic [31:0]     b4, b7;
  logic            neg;

  logic [4:0]  cnt;
  logic [63:0] acc;
  logic [63:0] mul_a, mul_b;
  logic [15:0] mul_chunk;
  logic [79:0] mul_wide;
  logic [63:0] mul_sum;
  logic        mul_last;
  logic        mul_state;

  logic [31:0] div_n, div_d;
  logic [31:0] div_r;
  logic [32:0] div_sh, div_diff;
  logic        div_bit;

  logic [63:0] den, mc64, absmc, absden, tq, b5, tval, pf;

  logic [TempW-1:0] res_t;
  logic [PresW-1:0] res_p;
  logic             res_dz, res_sat;
  logic             out_valid;

  // multiplier: one 16-bit slice of mul_b per cycle, product kept modulo 2^64
  assign mul_chunk = mul_b[{cnt[1:0], 4'd0} +: 16];
  assign mul_wide  = mul_a * mul_chunk;
  assign mul_sum   = acc + (mul_wide[63:0] << {cnt[1:0], 4'd0});
  assign mul_last  = (cnt[1:0] == 2'd3);

  // restoring divider step
  assign div_sh   = {div_r, div_n[31]};
  assign div_diff = div_sh - {1'b0, div_d};
  assign div_bit  = !div_diff[32];

  assign mc64   = sx16(coef_mcmd[31:16]);
  assign absmc  = mc64[63] ? (64'd0 - mc64) : mc64;
  assign den    = x1 + sx16(coef_mcmd[15:0]);
  assign absden = den[63] ? (64'd0 - den) : den;
  assign tq     = neg ? (64'd0 - {32'd0, div_n}) : {32'd0, div_n};
  assign b5     = x1 + tq;
  assign tval   = sdiv2(b5 + 64'd8, 6'd4);
  assign pf     = p + sdiv2(x1 + x2 + K_P_OFFSET, 6'd4);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (sample.valid) state_next = (sample.func == FUNC_PRES) ? S_PSQ : S_TX1;
      S_TX1:  if (mul_last) state_next = S_TDEN;
      S_TDEN: state_next = (den == 64'd0) ? S_OUT : S_TDIV;
      S_TDIV: if (cnt == 5'd31) state_next = S_TFIN;
      S_TFIN: state_next = S_OUT;
      S_PSQ:  if (mul_last) state_next = S_PX1A;
      S_PX1A: if (mul_last) state_next = S_PX2A;
      S_PX2A: if (mul_last) state_next = S_PB3;
      S_PB3:  state_next = S_PX1B;
      S_PX1B: if (mul_last) state_next = S_PX2B;
      S_PX2B: if (mul_last) state_next = S_PX3;
      S_PX3:  state_next = S_PB4;
      S_PB4:  if (mul_last) state_next = S_PB7;
      S_PB7:  if (mul_last) state_next = S_PDLD;
      S_PDLD: state_next = (b4 == 32'd0) ? S_OUT : S_PDIV;
      S_PDIV: if (cnt == 5'd31) state_next = S_PQ;
      S_PQ:   state_next = S_PF1;
      S_PF1:  if (mul_last) state_next = S_PF2;
      S_PF2:  if (mul_last) state_next = S_PF3;
      S_PF3:  if (mul_last) state_next = S_PFIN;
      S_PFIN: state_next = S_OUT;
      S_OUT:  if (!out_valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == S_IDLE);
    mul_state    = 1'b1;
    mul_a        = 64'd0;
    mul_b        = 64'd0;
    case (state)
      S_TX1: begin
        mul_a = {45'd0, raw} - zx16(coef_ac456[15:0]);
        mul_b = zx16(coef_ac456[31:16]);
      end
      S_PSQ: begin
        mul_a = b6;
        mul_b = b6;
      end
      S_PX1A: begin
        mul_a = sdiv2(sq, 6'd12);
        mul_b = sx16(coef_b12[15:0]);
      end
      S_PX2A: begin
        mul_a = b6;
        mul_b = sx16(coef_ac123[31:16]);
      end
      S_PX1B: begin
        mul_a = b6;
        mul_b = sx16(coef_ac123[15:0]);
      end
      S_PX2B: begin
        mul_a = sdiv2(sq, 6'd11);
        mul_b = sx16(coef_b12[31:16]);
      end
      S_PB4: begin
        mul_a = zx16(coef_ac456[47:32]);
        mul_b = {32'd0, x3[31:0] + K_B4_OFFSET[31:0]};
      end
      S_PB7: begin
        mul_a = {32'd0, {13'd0, raw} - b3[31:0]};
        mul_b = {32'd0, K_B7_SCALE >> oss};
      end
      S_PF1: begin
        mul_a = sdiv2(p, 6'd8);
        mul_b = sdiv2(p, 6'd8);
      end
      S_PF2: begin
        mul_a = x1;
        mul_b = K_P_SQ;
      end
      S_PF3: begin
        mul_a = p;
        mul_b = K_P_LIN;
      end
      default: mul_state = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      last_b5    <= 32'd0;
      coef_ac123 <= 48'd0;
      coef_ac456 <= 48'd0;
      coef_b12   <= 32'd0;
      coef_mcmd  <= 32'd0;
      oss        <= 2'd0;
      cnt        <= 5'd0;
      acc        <= 64'd0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_AC123: coef_ac123 <= cfg_data;
          REG_AC456: coef_ac456 <= cfg_data;
          REG_B12:   coef_b12   <= cfg_data[31:0];
          REG_MCMD:  coef_mcmd  <= cfg_data[31:0];
          REG_OSS:   oss        <= cfg_data[1:0];
          default: ;
        endcase
      end

      if (mul_state) begin
        cnt <= mul_last ? 5'd0 : cnt + 5'd1;
        acc <= mul_last ? 64'd0 : mul_sum;
      end

      if (state == S_TDIV || state == S_PDIV) begin
        cnt   <= cnt + 5'd1;
        div_r <= div_bit ? div_diff[31:0] : div_sh[31:0];
        div_n <= {div_n[30:0], div_bit};
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            func <= sample.func;
            raw  <= sample.raw_value;
            b6   <= {{32{last_b5[31]}}, last_b5} - K_B6_OFFSET;
          end
        end
        S_TX1:  if (mul_last) x1 <= sdiv2(mul_sum, 6'd15);
        S_TDEN: begin
          res_t   <= '0;
          res_p   <= '0;
          res_sat <= 1'b0;
          res_dz  <= (den == 64'd0);
          neg     <= den[63] ^ mc64[63];
          div_n   <= {absmc[20:0], 11'd0};
          div_d   <= absden[31:0];
          div_r   <= 32'd0;
        end
        S_TFIN: begin
          last_b5 <= b5[31:0];
          if ($signed(tval) > $signed(K_T_MAX)) begin
            res_t   <= K_T_MAX[15:0];
            res_sat <= 1'b1;
          end else if ($signed(tval) < $signed(K_T_MIN)) begin
            res_t   <= K_T_MIN[15:0];
            res_sat <= 1'b1;
          end else begin
            res_t <= tval[15:0];
          end
        end
        S_PSQ:  if (mul_last) sq <= mul_sum;
        S_PX1A: if (mul_last) x1 <= sdiv2(mul_sum, 6'd11);
        S_PX2A: if (mul_last) x3 <= x1 + sdiv2(mul_sum, 6'd11);
        S_PB3:  b3 <= sdiv2(((x3 + (sx16(coef_ac123[47:32]) << 2)) << oss) + 64'd2, 6'd2);
        S_PX1B: if (mul_last) x1 <= sdiv2(mul_sum, 6'd13);
        S_PX2B: if (mul_last) x2 <= sdiv2(mul_sum, 6'd14);
        S_PX3:  x3 <= sdiv2(x1 + x2 + 64'd2, 6'd2);
        S_PB4:  if (mul_last) b4 <= {15'd0, mul_sum[31:15]};
        S_PB7:  if (mul_last) b7 <= mul_sum[31:0];
        S_PDLD: begin
          res_t   <= '0;
          res_p   <= '0;
          res_sat <= 1'b0;
          res_dz  <= (b4 == 32'd0);
          div_n   <= b7[31] ? b7 : {b7[30:0], 1'b0};
          div_d   <= b4;
          div_r   <= 32'd0;
        end
        S_PQ:   p  <= b7[31] ? {31'd0, div_n, 1'b0} : {32'd0, div_n};
        S_PF1:  if (mul_last) x1 <= mul_sum;
        S_PF2:  if (mul_last) x1 <= sdiv2(mul_sum, 6'd16);
        S_PF3:  if (mul_last) x2 <= sdiv2(mul_sum, 6'd16);
        S_PFIN: begin
          if (pf[63]) begin
            res_p   <= '0;
            res_sat <= 1'b1;
          end else if (pf > K_P_MAX) begin
            res_p   <= K_P_MAX[19:0];
            res_sat <= 1'b1;
          end else begin
            res_p <= pf[19:0];
          end
        end
        default: ;
      endcase

      if (state == S_OUT && (!out_valid || result.ready)) begin
        out_valid                 <= 1'b1;
        result.kind               <= func;
        result.temperature_tenths <= res_t;
        result.pressure_pa        <= res_p;
        result.divide_by_zero     <= res_dz;
        result.saturated          <= res_sat;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;

  a_dz_sat_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.divide_by_zero && result.saturated))
    else $error("divide_by_zero and saturated both set");

  a_temp_no_pres: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == FUNC_TEMP) |-> (result.pressure_pa == '0))
    else $error("temperature result carries pressure");

  a_pres_no_temp: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == FUNC_PRES) |-> (result.temperature_tenths == '0))
    else $error("pressure result carries temperature");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state != S_IDLE))
    else $error("sequencer did not start");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_TDIV || state == S_PDIV) |-> (div_d != 32'd0))
    else $error("divider running with zero divisor");

endmodule

// ===== tb/bc_checker.sv =====
// Checker: watches config writes and both channels, predicts each result and compares it.
`timescale 1ns / 100ps
module bc_checker import bc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  bc_in_if                     smp,
  bc_out_if                    res,
  output int                   fails,
  output int                   pending
);

  typedef struct packed {
    logic                    kind;
    logic signed [TempW-1:0] tenths;
    logic [PresW-1:0]        pascals;
    logic                    dbz;
    logic                    sat;
  } reading_t;

  logic [47:0] ac123, ac456;
  logic [31:0] b12, mcmd;
  logic [1:0]  oss;
  logic [31:0] b5_store;
  reading_t    compensated_q[$];

  assign pending = compensated_q.size();

  function automatic longint sf(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint uf(input logic [15:0] v);
    return longint'({48'd0, v});
  endfunction

  function automatic reading_t compensate(input logic func, input logic [RawW-1:0] raw);
    reading_t    r;
    longint      x1, x2, x3, den, b5, t, b6, b3, p;
    logic [63:0] wide;
    logic [31:0] prod, b4, b7, dbl;
    r = '0;
    r.kind = func;
    if (func == FUNC_TEMP) begin
      x1 = (uf(raw[15:0]) + longint'({45'd0, raw}) - uf(raw[15:0]) - uf(ac456[15:0]))
           * uf(ac456[31:16]) / 32768;
      den = x1 + sf(mcmd[15:0]);
      if (den == 0) begin
        r.dbz = 1'b1;
      end else begin
        b5 = x1 + sf(mcmd[31:16]) * 2048 / den;
        b5_store = b5[31:0];
        t = (b5 + 8) / 16;
        if (t > 32767) begin
          t = 32767;
          r.sat = 1'b1;
        end
        if (t < -32768) begin
          t = -32768;
          r.sat = 1'b1;
        end
        r.tenths = t[15:0];
      end
    end else begin
      b6 = longint'($signed(b5_store)) - 4000;
      x1 = sf(b12[15:0]) * (b6 * b6 / 4096) / 2048;
      x2 = sf(ac123[31:16]) * b6 / 2048;
      x3 = x1 + x2;
      b3 = ((sf(ac123[47:32]) * 4 + x3) * longint'(64'd1 << oss) + 2) / 4;
      x1 = sf(ac123[15:0]) * b6 / 8192;
      x2 = sf(b12[31:16]) * (b6 * b6 / 2048) / 16384;
      x3 = (x1 + x2 + 2) / 4;
      wide = x3 + 32768;
      prod = {16'd0, ac456[47:32]} * wide[31:0];
      b4 = prod >> 15;
      wide = b3;
      b7 = ({13'd0, raw} - wide[31:0]) * (32'd50000 >> oss);
      if (b4 == 0) begin
        r.dbz = 1'b1;
      end else begin
        if (b7 < 32'h8000_0000) begin
          dbl = b7 * 2;
          p = longint'({32'd0, dbl / b4});
        end else begin
          p = longint'({32'd0, b7 / b4}) * 2;
        end
        x1 = (p / 256) * (p / 256);
        x1 = x1 * 3038 / 65536;
        x2 = (-7357 * p) / 65536;
        p = p + (x1 + x2 + 3791) / 16;
        if (p > 1048575) begin
          p = 1048575;
          r.sat = 1'b1;
        end
        if (p < 0) begin
          p = 0;
          r.sat = 1'b1;
        end
        r.pascals = p[19:0];
      end
    end
    return r;
  endfunction

  task automatic report(input string field, input longint got, input longint exp_v);
    $display("%0t: %s got %0d, want %0d", $realtime, field, got, exp_v);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    reading_t e;
    if (rst) begin
      ac123 <= '0;
      ac456 <= '0;
      b12 <= '0;
      mcmd <= '0;
      oss <= '0;
      b5_store = '0;
      compensated_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_AC123: ac123 <= cfg_data[47:0];
          REG_AC456: ac456 <= cfg_data[47:0];
          REG_B12:   b12 <= cfg_data[31:0];
          REG_MCMD:  mcmd <= cfg_data[31:0];
          REG_OSS:   oss <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready)
        compensated_q.push_back(compensate(smp.func, smp.raw_value));
      if (res.valid && res.ready) begin
        if (compensated_q.size() == 0) begin
          report("unexpected transfer", res.kind, -1);
        end else begin
          e = compensated_q.pop_front();
          if (res.kind !== e.kind) report("kind", res.kind, e.kind);
          if (res.temperature_tenths !== e.tenths)
            report("temperature_tenths", res.temperature_tenths, e.tenths);
          if (res.pressure_pa !== e.pascals) report("pressure_pa", res.pressure_pa, e.pascals);
          if (res.divide_by_zero !== e.dbz) report("divide_by_zero", res.divide_by_zero, e.dbz);
          if (res.saturated !== e.sat) report("saturated", res.saturated, e.sat);
        end
      end
    end
  end

endmodule

// ===== tb/barometer_compensation_tb.sv =====
// Testbench top: drives config, raw readings and result back-pressure; gives the verdict.
`timescale 1ns / 100ps
module barometer_compensation_tb;
  import bc_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int Settle     = 120;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  int                   fails, pending, cycles;
  int                   stall_left, mode_left, rx_mode;
  int                   burst_left;
  bit                   gaps_on;

  bc_in_if  smp ();
  bc_out_if res ();

  barometer_compensation dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(smp), .result(res)
  );

  bc_checker chk (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .smp(smp), .res(res), .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure: always ready, coin flip, or long stalls
  always @(negedge clk) begin
    logic r;
    if (mode_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      r = 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_mode == 0) begin
      r = 1'b1;
    end else if (rx_mode == 1) begin
      r = 1'($urandom_range(0, 1));
    end else begin
      r = 1'b1;
      if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 40);
    end
    res.ready <= r;
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [47:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic send(input logic func, input logic [RawW-1:0] raw);
    if (gaps_on) begin
      if (burst_left == 0) begin
        smp.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    smp.valid <= 1'b1;
    smp.func <= func;
    smp.raw_value <= raw;
    do @(posedge clk); while (!smp.ready);
    @(negedge clk);
  endtask

  // kind 0: near-typical calibration, 1: random words, 2: sign extremes
  task automatic load_coefs(input int kind, input logic [1:0] os);
    logic [15:0] w[11];
    if (kind == 0) begin
      w = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
            16'd6190, 16'd4, -16'sd8711, 16'd2868, 16'd0};
      foreach (w[i]) w[i] = w[i] + 16'($signed($urandom_range(0, 64)) - 32);
    end else if (kind == 1) begin
      foreach (w[i]) w[i] = 16'($urandom);
    end else begin
      foreach (w[i]) w[i] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    end
    write_reg(REG_AC123, {w[0], w[1], w[2]});
    write_reg(REG_AC456, {w[3], w[4], w[5]});
    write_reg(REG_B12, {16'd0, w[6], w[7]});
    write_reg(REG_MCMD, {16'd0, w[8], w[9]});
    write_reg(REG_OSS, {46'd0, os});
  endtask

  task automatic random_item(input logic [1:0] os);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      send(FUNC_TEMP, RawW'($urandom_range(20000, 40000)));
      send(FUNC_PRES, RawW'($urandom_range(15000, 45000)) << os);
    end else if (sel < 9) begin
      send(1'($urandom_range(0, 1)), RawW'($urandom));
    end else begin
      send(FUNC_PRES, RawW'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.func = FUNC_TEMP;
    smp.raw_value = '0;
    res.ready = 1'b0;
    stall_left = 0;
    mode_left = 0;
    rx_mode = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // all-zero calibration: pressure before temperature, both divisors zero
    send(FUNC_PRES, 19'd23843);
    send(FUNC_TEMP, 19'd27898);
    send(FUNC_PRES, '1);
    drain();

    // typical calibration set
    write_reg(REG_AC123, {16'd408, -16'sd72, -16'sd14383});
    write_reg(REG_AC456, {16'd32741, 16'd32757, 16'd23153});
    write_reg(REG_B12, {16'd0, 16'd6190, 16'd4});
    write_reg(REG_MCMD, {16'd0, -16'sd8711, 16'd2868});
    write_reg(REG_OSS, 48'd0);
    write_reg(3'd5, '1);
    write_reg(3'd7, '1);
    send(FUNC_TEMP, 19'd27898);
    send(FUNC_PRES, 19'd23843);
    send(FUNC_TEMP, 19'd0);
    send(FUNC_PRES, 19'd0);
    send(FUNC_TEMP, '1);
    send(FUNC_PRES, '1);
    send(FUNC_TEMP, 19'h0FFFF);
    send(FUNC_PRES, 19'h2AAAA);
    drain();

    // temperature clipping both ways, then zero temperature divisor
    write_reg(REG_AC456, {16'd32741, 16'd0, 16'd23153});
    write_reg(REG_MCMD, {16'd0, -16'sd32768, 16'd1});
    write_reg(REG_OSS, 48'd3);
    send(FUNC_TEMP, 19'd100);
    send(FUNC_PRES, 19'h55555);
    drain();
    write_reg(REG_MCMD, {16'd0, 16'd32767, 16'd1});
    send(FUNC_TEMP, 19'd100);
    send(FUNC_PRES, '1);
    drain();
    write_reg(REG_MCMD, {16'd0, 16'd32767, 16'd0});
    send(FUNC_TEMP, 19'd5);
    send(FUNC_PRES, 19'd1000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      logic [1:0] os;
      os = 2'(ph);
      load_coefs(ph % 3, os);
      gaps_on = (ph % 4) != 1;
      for (int n = 0; n < 113; n++) begin
        random_item(os);
        if (n == 60 && ph == 2) begin
          smp.valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bc_pkg.sv
hdl/bc_in_if.sv
hdl/bc_out_if.sv
hdl/barometer_compensation.sv
tb/bc_checker.sv
tb/barometer_compensation_tb.sv
